// ----- hw/rtl/pse_pkg.sv -----
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants of the postfix stack evaluator
// Beat types, command and operator codes, fixed-point limits and sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

    // Sizes
    localparam int STACK_DEPTH   = 128;
    localparam int FRACTION_BITS = 16;
    localparam int VAL_W         = 48;
    localparam int OPND_W        = 47;
    localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
    localparam int HALF_W        = 32;
    localparam int PROD_W        = 2 * VAL_W;
    localparam int DIVD_W        = VAL_W + FRACTION_BITS;
    localparam int DIV_STEPS     = DIVD_W;
    localparam int STEP_W        = $clog2(DIV_STEPS);
    localparam int MUL_STEPS     = 4;

    // Token commands
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_OP   = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;

    // Operators
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef logic signed [VAL_W-1:0] pse_val_t;

    localparam pse_val_t POS_MAX = pse_val_t'({1'b0, {(VAL_W-1){1'b1}}});
    localparam pse_val_t NEG_MIN = pse_val_t'({1'b1, {(VAL_W-1){1'b0}}});

    typedef struct packed {
        logic [1:0]        cmd;
        logic [OPND_W-1:0] operand_value;
        logic [1:0]        op_code;
    } pse_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic                    underflow_seen;
        logic                    divide_by_zero_seen;
        logic                    saturated_seen;
    } pse_out_t;

    // Shift command to the row of stack cells
    typedef struct packed {
        logic push;
        logic pop;
    } pse_stk_ctl_t;

    // Arithmetic unit status, sat/div0 valid with done
    typedef struct packed {
        logic done;
        logic sat;
        logic div0;
    } pse_alu_st_t;

    typedef struct packed {
        logic under;
        logic div0;
        logic sat;
    } pse_flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pse_cell.sv -----
// ----------------------------------------------------------------------------
// pse_cell: one entry of the shifting value stack
// Takes the value from above on a push and from below on a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_cell (
    input  wire logic                  clk,
    input  wire pse_pkg::pse_stk_ctl_t ctl,
    input  wire pse_pkg::pse_val_t     above,
    input  wire pse_pkg::pse_val_t     below,
    output pse_pkg::pse_val_t          value
);
    import pse_pkg::*;

    pse_val_t value_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            value_reg <= above;
        end
        else if (ctl.pop)
        begin
            value_reg <= below;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pse_alu.sv -----
// ----------------------------------------------------------------------------
// pse_alu: multi-cycle fixed-point arithmetic unit
// Add/sub straight from idle, multiply on a shared 32x32 multiplier over four
// partial products, divide by restoring long division one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_alu (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [1:0]        op,
    input  wire pse_pkg::pse_val_t left,
    input  wire pse_pkg::pse_val_t right,
    output pse_pkg::pse_val_t      result,
    output pse_pkg::pse_alu_st_t   status
);
    import pse_pkg::*;

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MUL  = 4'b0010,
        A_DIV  = 4'b0100,
        A_FIN  = 4'b1000
    } alu_state_t;

    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_1  = 2'd1;
    localparam logic [1:0] SH_2  = 2'd2;

    function automatic logic [VAL_W-1:0] mag_of(input pse_val_t v);
        mag_of = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
    endfunction

    alu_state_t          state_reg, state_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    logic                is_div_reg, is_div_next;
    logic                neg_reg, neg_next;
    logic [DIVD_W-1:0]   dvd_reg, dvd_next;
    logic [VAL_W-1:0]    dsr_reg, dsr_next;
    logic [VAL_W-1:0]    rem_reg, rem_next;
    logic [VAL_W-1:0]    quo_reg, quo_next;
    logic                big_reg, big_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [2*HALF_W-1:0] prod_reg, prod_next;
    logic [1:0]          sh_reg, sh_next;
    pse_val_t            res_reg, res_next;
    logic                sat_reg, sat_next;
    logic                div0_reg, div0_next;

    // add / subtract
    logic signed [VAL_W:0] as_sum;
    logic                  as_ovf;
    pse_val_t              as_res;

    // multiply datapath
    logic [VAL_W-1:0]    opa;
    logic [HALF_W-1:0]   mul_x, mul_y;
    logic [2*HALF_W-1:0] pp;
    logic [PROD_W-1:0]   addend;

    // divide step
    logic [VAL_W:0]      r_try;
    logic                r_ge;

    // finalise
    logic [PROD_W-1:0]   shifted;
    logic [VAL_W-1:0]    fin_mag, lim;
    logic                fin_over, fin_sat;
    pse_val_t            fin_res;

    always_comb
    begin
        as_sum = (op == OP_SUB) ? ({left[VAL_W-1], left} - {right[VAL_W-1], right})
                                : ({left[VAL_W-1], left} + {right[VAL_W-1], right});
        as_ovf = as_sum[VAL_W] ^ as_sum[VAL_W-1];
        as_res = as_ovf ? (as_sum[VAL_W] ? NEG_MIN : POS_MAX) : pse_val_t'(as_sum[VAL_W-1:0]);
    end

    assign opa = dvd_reg[DIVD_W-1 -: VAL_W];

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:
            begin
                mul_x   = opa[HALF_W-1:0];
                mul_y   = dsr_reg[HALF_W-1:0];
                sh_next = SH_0;
            end
            2'd1:
            begin
                mul_x   = opa[HALF_W-1:0];
                mul_y   = HALF_W'(dsr_reg[VAL_W-1:HALF_W]);
                sh_next = SH_1;
            end
            2'd2:
            begin
                mul_x   = HALF_W'(opa[VAL_W-1:HALF_W]);
                mul_y   = dsr_reg[HALF_W-1:0];
                sh_next = SH_1;
            end
            default:
            begin
                mul_x   = HALF_W'(opa[VAL_W-1:HALF_W]);
                mul_y   = HALF_W'(dsr_reg[VAL_W-1:HALF_W]);
                sh_next = SH_2;
            end
        endcase
        pp = mul_x * mul_y;

        case (sh_reg)
            SH_0:    addend = PROD_W'(prod_reg);
            SH_1:    addend = PROD_W'(prod_reg) << HALF_W;
            default: addend = PROD_W'(prod_reg) << (2 * HALF_W);
        endcase
    end

    always_comb
    begin
        r_try = {rem_reg, dvd_reg[DIVD_W-1]};
        r_ge  = r_try >= {1'b0, dsr_reg};
    end

    always_comb
    begin
        shifted  = acc_reg >> FRACTION_BITS;
        fin_mag  = is_div_reg ? quo_reg : shifted[VAL_W-1:0];
        fin_over = is_div_reg ? big_reg : (|shifted[PROD_W-1:VAL_W]);
        lim      = neg_reg ? VAL_W'(NEG_MIN) : VAL_W'(POS_MAX);
        fin_sat  = fin_over || (fin_mag > lim);
        if (fin_sat)
        begin
            fin_res = neg_reg ? NEG_MIN : POS_MAX;
        end
        else
        begin
            fin_res = neg_reg ? pse_val_t'(-fin_mag) : pse_val_t'(fin_mag);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        is_div_next = is_div_reg;
        neg_next    = neg_reg;
        dvd_next    = dvd_reg;
        dsr_next    = dsr_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        big_next    = big_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        res_next    = res_reg;
        sat_next    = sat_reg;
        div0_next   = div0_reg;

        unique case (state_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    neg_next  = left[VAL_W-1] ^ right[VAL_W-1];
                    dvd_next  = DIVD_W'(mag_of(left)) << FRACTION_BITS;
                    dsr_next  = mag_of(right);
                    step_next = '0;
                    acc_next  = '0;
                    rem_next  = '0;
                    quo_next  = '0;
                    big_next  = 1'b0;
                    sat_next  = 1'b0;
                    div0_next = 1'b0;
                    unique case (op) inside
                        OP_ADD, OP_SUB:
                        begin
                            res_next  = as_res;
                            sat_next  = as_ovf;
                            done_next = 1'b1;
                        end
                        OP_MUL:
                        begin
                            is_div_next = 1'b0;
                            state_next  = A_MUL;
                        end
                        default:
                        begin
                            if (right == '0)
                            begin
                                res_next  = left[VAL_W-1] ? NEG_MIN : POS_MAX;
                                div0_next = 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                is_div_next = 1'b1;
                                state_next  = A_DIV;
                            end
                        end
                    endcase
                end
            end
            A_MUL:
            begin
                // product issued in step k is accumulated in step k+1
                if (step_reg != STEP_W'(MUL_STEPS))
                begin
                    prod_next = pp;
                end
                if (step_reg != '0)
                begin
                    acc_next = acc_reg + addend;
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MUL_STEPS))
                begin
                    state_next = A_FIN;
                end
            end
            A_DIV:
            begin
                dvd_next = dvd_reg << 1;
                rem_next = r_ge ? VAL_W'(r_try - {1'b0, dsr_reg}) : r_try[VAL_W-1:0];
                if (!big_reg)
                begin
                    quo_next = {quo_reg[VAL_W-2:0], r_ge};
                end
                big_next  = big_reg | quo_reg[VAL_W-1];
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = A_FIN;
                end
            end
            A_FIN:
            begin
                res_next   = fin_res;
                sat_next   = fin_sat;
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_div_reg <= is_div_next;
        neg_reg    <= neg_next;
        dvd_reg    <= dvd_next;
        dsr_reg    <= dsr_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        big_reg    <= big_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        sh_reg     <= sh_next;
        res_reg    <= res_next;
        sat_reg    <= sat_next;
        div0_reg   <= div0_next;
    end

    assign result = res_reg;
    assign status = '{done: done_reg, sat: sat_reg, div0: div0_reg};

endmodule

`default_nettype wire

// ----- hw/rtl/postfix_stack_evaluator.sv -----
// ----------------------------------------------------------------------------
// postfix_stack_evaluator: Reverse Polish evaluator on a Q31.16 value stack
//
// Tokens arrive on the tok channel (valid/ready), one beat per token:
// cmd 0 pushes operand_value, cmd 1 pops right then left operand, applies
// op_code and pushes the result, cmd 2 pops the top and sends it on the res
// channel with the sticky flags of the expression, then clears the flags.
// cmd 3 is accepted and ignored.
// Push, end and unused codes are taken in S_IDLE; an operator runs through
// S_POP2 and S_ALU, multiply as four partial products on one 32x32 multiplier
// and divide one quotient bit a cycle over 64 bits - the divider loop sets
// the worst-case rate. No token is taken until the operator is done.
// A result beat appears the cycle after its end token and sits in an output
// register; further tokens are taken while it waits, but a second end token
// is held off until the waiting beat is taken.
// Reset clears the stack depth, flags, output valid and all sequencers; the
// stack cells themselves are not cleared, nothing below the depth is read.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_stack_evaluator (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             tok_valid,
    output logic                  tok_ready,
    input  wire pse_pkg::pse_in_t tok,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output pse_pkg::pse_out_t     res
);
    import pse_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP2 = 3'b010,
        S_ALU  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    pse_flags_t       flags_reg, flags_next;
    logic             res_valid_reg, res_valid_next;
    pse_out_t         res_reg, res_next;
    pse_val_t         left_reg, left_next;
    pse_val_t         right_reg, right_next;
    logic [1:0]       op_reg, op_next;

    pse_stk_ctl_t     stk_ctl;
    pse_val_t         push_data;
    pse_val_t         stk_val [STACK_DEPTH];

    logic             alu_start;
    pse_val_t         alu_res;
    pse_alu_st_t      alu_st;

    logic             tok_acc;
    logic             stk_empty, stk_full, stk_pair;

    // ------------------------------------------------------------------
    // Stack: a row of cells, cell 0 is the top of stack. A push shifts
    // every entry one place down, a pop shifts one place up.
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < STACK_DEPTH; gi++)
    begin : g_cell
        pse_val_t above, below;

        if (gi == 0)
        begin : g_first
            assign above = push_data;
        end
        else
        begin : g_inner
            assign above = stk_val[gi-1];
        end

        if (gi == STACK_DEPTH - 1)
        begin : g_last
            assign below = stk_val[gi];
        end
        else
        begin : g_body
            assign below = stk_val[gi+1];
        end

        pse_cell u_cell (
            .clk   (clk),
            .ctl   (stk_ctl),
            .above (above),
            .below (below),
            .value (stk_val[gi])
        );
    end

    pse_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (alu_start),
        .op     (op_reg),
        .left   (left_reg),
        .right  (right_reg),
        .result (alu_res),
        .status (alu_st)
    );

    assign stk_empty = (cnt_reg == '0);
    assign stk_full  = (cnt_reg >= CNT_W'(STACK_DEPTH));
    assign stk_pair  = (cnt_reg >= CNT_W'(2));

    // Only an end token needs the output register to be free
    assign tok_ready = (state_reg == S_IDLE) &&
                       ((tok.cmd != CMD_END) || !res_valid_reg || res_ready);
    assign tok_acc   = tok_valid && tok_ready;

    // Result of the arithmetic unit goes back on the stack; otherwise the
    // token's operand (always nonnegative)
    assign push_data = (state_reg == S_ALU) ? alu_res
                                            : pse_val_t'({1'b0, tok.operand_value});

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        flags_next     = flags_reg;
        res_next       = res_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        op_next        = op_reg;
        stk_ctl        = '0;
        alu_start      = 1'b0;
        res_valid_next = res_valid_reg && !res_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (tok_acc)
                begin
                    unique case (tok.cmd)
                        CMD_PUSH:
                        begin
                            // full stack: value dropped, no flag
                            if (!stk_full)
                            begin
                                stk_ctl.push = 1'b1;
                                cnt_next     = cnt_reg + CNT_W'(1);
                            end
                        end
                        CMD_OP:
                        begin
                            // both operands read now; missing ones read as zero
                            right_next = stk_empty ? pse_val_t'(0) : stk_val[0];
                            left_next  = stk_pair ? stk_val[1] : pse_val_t'(0);
                            op_next    = tok.op_code;
                            if (!stk_pair)
                            begin
                                flags_next.under = 1'b1;
                            end
                            if (!stk_empty)
                            begin
                                stk_ctl.pop = 1'b1;
                                cnt_next    = cnt_reg - CNT_W'(1);
                            end
                            state_next = S_POP2;
                        end
                        CMD_END:
                        begin
                            res_next.result_value        = stk_empty ? pse_val_t'(0)
                                                                     : stk_val[0];
                            res_next.underflow_seen      = flags_reg.under | stk_empty;
                            res_next.divide_by_zero_seen = flags_reg.div0;
                            res_next.saturated_seen      = flags_reg.sat;
                            res_valid_next               = 1'b1;
                            flags_next                   = '0;
                            if (!stk_empty)
                            begin
                                stk_ctl.pop = 1'b1;
                                cnt_next    = cnt_reg - CNT_W'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_POP2:
            begin
                if (!stk_empty)
                begin
                    stk_ctl.pop = 1'b1;
                    cnt_next    = cnt_reg - CNT_W'(1);
                end
                alu_start  = 1'b1;
                state_next = S_ALU;
            end
            S_ALU:
            begin
                if (alu_st.done)
                begin
                    // the operator's pops leave the stack below full, so there is always room here
                    if (!stk_full)
                    begin
                        stk_ctl.push = 1'b1;
                        cnt_next     = cnt_reg + CNT_W'(1);
                    end
                    flags_next.sat  = flags_reg.sat | alu_st.sat;
                    flags_next.div0 = flags_reg.div0 | alu_st.div0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            flags_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            flags_reg     <= flags_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        op_reg    <= op_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(stk_ctl.push && stk_ctl.pop))
        else $error("push and pop in the same cycle");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        stk_ctl.pop |=> cnt_reg == $past(cnt_reg) - CNT_W'(1))
        else $error("pop did not lower the depth by one");

    a_alu_done: assert property (@(posedge clk) disable iff (!rst_n)
        alu_st.done |-> state_reg == S_ALU)
        else $error("arithmetic result outside the wait state");

    a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_acc && tok.cmd == CMD_END) |=> flags_reg == '0)
        else $error("flags not cleared after end token");

endmodule

`default_nettype wire
